// ===== design/bbjm_pkg.sv =====
`default_nettype none

package bbjm_pkg;

    // Byte addresses carry one bit above 24 so PC+8 never wraps.
    localparam int FAW = 25;
    localparam int PC_W = 24;
    localparam int WORD_W = 72;

    localparam logic [FAW-1:0] FRAME_BYTES = 25'h01_0000;
    localparam logic [FAW-1:0] PC_VEC_ADDR = 25'h00_0002;

    localparam logic [1:0] ACT_WRITE = 2'd0;
    localparam logic [1:0] ACT_RUN = 2'd1;
    localparam logic [1:0] ACT_READ = 2'd2;

    typedef struct packed {
        logic rd;
        logic wr;
        logic [FAW-1:0] addr;
        logic [7:0] wdata;
    } t_mem_req;

endpackage

`default_nettype wire

// ===== design/byte_byte_jump_machine.sv =====
`default_nettype none

// Byte copy-and-jump machine over a single-port byte memory of MEM_BYTES bytes.
// Input channel (i_valid / o_stall) carries one action per transfer:
//   write      - store i_data at i_address.
//   run frame  - load PC from bytes 2..4, then execute STEPS_PER_FRAME
//                instructions (copy mem[A] to mem[B], jump to C).
//                Every instruction makes nine fetch reads, one source
//                read and one write, one access per cycle on the single
//                memory port.
//   read frame - byte at i_address + i_frame_offset when the frame ends
//                before the last byte of memory, zero otherwise.
// Every transfer in gives exactly one transfer out (o_valid / i_stall) on
// o_read_data, zero for all but a frame read. One item is worked at a time;
// o_stall is high while an item is in progress. The result sits in an output
// register, so the next item is taken while a stalled result still waits.
// After reset the block sweeps the memory to zero, one byte per cycle, with
// o_stall high; the program counter resets to 0.

module byte_byte_jump_machine #(
    parameter int MEM_BYTES       = 1048576,
    parameter int STEPS_PER_FRAME = 65536
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [1:0]  i_action,
    input  wire logic [19:0] i_address,
    input  wire logic [15:0] i_frame_offset,
    input  wire logic [7:0]  i_data,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [7:0]       o_read_data
);

    localparam int AW = $clog2(MEM_BYTES);
    localparam int SW = (STEPS_PER_FRAME > 1) ? $clog2(STEPS_PER_FRAME) : 1;
    localparam logic [SW-1:0] STEP_LAST = SW'(STEPS_PER_FRAME - 1);
    localparam logic [AW-1:0] CLR_LAST = AW'(MEM_BYTES - 1);
    localparam int FAW = bbjm_pkg::FAW;

    typedef enum logic [8:0] {
        ST_CLEAR  = 9'b000000001,
        ST_IDLE   = 9'b000000010,
        ST_PCLOAD = 9'b000000100,
        ST_PCSET  = 9'b000001000,
        ST_FETCH  = 9'b000010000,
        ST_SRC    = 9'b000100000,
        ST_COPY   = 9'b001000000,
        ST_RDWAIT = 9'b010000000,
        ST_DONE   = 9'b100000000
    } t_state;

    t_state r_state, n_state;
    logic [AW-1:0] r_clr, n_clr;
    logic [3:0] r_idx, n_idx;
    logic [SW-1:0] r_step, n_step;
    logic [bbjm_pkg::PC_W-1:0] r_pc, n_pc;
    logic [bbjm_pkg::WORD_W-1:0] r_word;
    logic r_gather, n_gather;
    logic [7:0] r_res, n_res;
    logic r_out_valid;
    logic [7:0] r_read_data;

    bbjm_pkg::t_mem_req mem_req;
    logic [7:0] mem_byte;
    logic [FAW-1:0] add_a, add_b, add_sum;
    logic frame_ok;
    logic out_free;

    // Shared address adder: base plus byte index (or frame offset).
    assign add_sum  = add_a + add_b;
    assign frame_ok = (FAW'(i_address) + bbjm_pkg::FRAME_BYTES) < FAW'(MEM_BYTES);
    assign out_free = !r_out_valid || !i_stall;

    bbjm_mem #(
        .MEM_BYTES(MEM_BYTES)
    ) u_mem (
        .i_clk  (i_clk),
        .i_req  (mem_req),
        .o_rdata(mem_byte)
    );

    always_comb begin
        n_state  = r_state;
        n_clr    = r_clr;
        n_idx    = r_idx;
        n_step   = r_step;
        n_pc     = r_pc;
        n_res    = r_res;
        n_gather = 1'b0;
        add_a    = '0;
        add_b    = FAW'(r_idx);
        mem_req  = '0;

        case (r_state)
            ST_CLEAR: begin
                // Zero one byte per cycle until the sweep ends.
                mem_req.wr   = 1'b1;
                mem_req.addr = FAW'(r_clr);
                n_clr        = r_clr + AW'(1);
                if (r_clr == CLR_LAST) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_valid) begin
                    n_res = 8'd0;
                    case (i_action)
                        bbjm_pkg::ACT_WRITE: begin
                            mem_req.wr    = 1'b1;
                            mem_req.addr  = FAW'(i_address);
                            mem_req.wdata = i_data;
                            n_state       = ST_DONE;
                        end
                        bbjm_pkg::ACT_RUN: begin
                            n_idx   = 4'd0;
                            n_state = ST_PCLOAD;
                        end
                        bbjm_pkg::ACT_READ: begin
                            add_a = FAW'(i_address);
                            add_b = FAW'(i_frame_offset);
                            if (frame_ok) begin
                                mem_req.rd   = 1'b1;
                                mem_req.addr = add_sum;
                                n_state      = ST_RDWAIT;
                            end else begin
                                n_state = ST_DONE;
                            end
                        end
                        default: begin
                            n_state = ST_DONE;
                        end
                    endcase
                end
            end
            ST_PCLOAD: begin
                // Gather the start vector, bytes 2..4.
                add_a        = bbjm_pkg::PC_VEC_ADDR;
                mem_req.rd   = 1'b1;
                mem_req.addr = add_sum;
                n_gather     = 1'b1;
                n_idx        = r_idx + 4'd1;
                if (r_idx == 4'd2) begin
                    n_state = ST_PCSET;
                end
            end
            ST_PCSET: begin
                n_pc    = {r_word[15:0], mem_byte};
                n_idx   = 4'd0;
                n_step  = '0;
                n_state = ST_FETCH;
            end
            ST_FETCH: begin
                // Nine instruction bytes at PC, no wrap at 24 bits.
                add_a        = FAW'(r_pc);
                mem_req.rd   = 1'b1;
                mem_req.addr = add_sum;
                n_gather     = 1'b1;
                n_idx        = r_idx + 4'd1;
                if (r_idx == 4'd8) begin
                    n_state = ST_SRC;
                end
            end
            ST_SRC: begin
                // Bytes 0..7 are in; A is complete.
                mem_req.rd   = 1'b1;
                mem_req.addr = FAW'(r_word[63:40]);
                n_state      = ST_COPY;
            end
            ST_COPY: begin
                mem_req.wr    = 1'b1;
                mem_req.addr  = FAW'(r_word[47:24]);
                mem_req.wdata = mem_byte;
                n_pc          = r_word[23:0];
                n_idx         = 4'd0;
                n_step        = r_step + SW'(1);
                if (r_step == STEP_LAST) begin
                    n_res   = 8'd0;
                    n_state = ST_DONE;
                end else begin
                    n_state = ST_FETCH;
                end
            end
            ST_RDWAIT: begin
                n_res   = mem_byte;
                n_state = ST_DONE;
            end
            ST_DONE: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr       <= '0;
            r_pc        <= '0;
            r_gather    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_clr    <= n_clr;
            r_pc     <= n_pc;
            r_gather <= n_gather;
            // Drop the result once taken; load a new one when the slot is free.
            if (r_out_valid && !i_stall) begin
                r_out_valid <= 1'b0;
            end
            if (r_state == ST_DONE && out_free) begin
                r_out_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx  <= n_idx;
        r_step <= n_step;
        r_res  <= n_res;
        // Advance the byte gather as read data arrives.
        if (r_gather) begin
            r_word <= {r_word[bbjm_pkg::WORD_W-9:0], mem_byte};
        end
        if (r_state == ST_DONE && out_free) begin
            r_read_data <= r_res;
        end
    end

    assign o_stall     = (r_state != ST_IDLE);
    assign o_valid     = r_out_valid;
    assign o_read_data = r_read_data;

    a_port_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(mem_req.rd && mem_req.wr))
        else $error("memory read and write in the same cycle");

    a_copy_after_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_COPY) |-> ($past(r_state) == ST_SRC))
        else $error("copy without a source read");

    a_gather_origin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_gather |-> ($past(r_state) == ST_FETCH || $past(r_state) == ST_PCLOAD))
        else $error("byte gather outside fetch");

    a_no_result_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CLEAR) |-> !r_out_valid)
        else $error("result during clearing sweep");

    a_result_needs_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == ST_DONE))
        else $error("result without finished item");

endmodule

`default_nettype wire

// ===== design/bbjm_mem.sv =====
`default_nettype none

module bbjm_mem #(
    parameter int MEM_BYTES = 1048576
) (
    input  wire logic               i_clk,
    input  wire bbjm_pkg::t_mem_req i_req,
    output logic [7:0]              o_rdata
);

    localparam int AW = $clog2(MEM_BYTES);

    logic [7:0] r_mem [MEM_BYTES];
    logic [7:0] r_rdata;
    logic       r_hit;
    logic       in_range;

    assign in_range = i_req.addr < bbjm_pkg::FAW'(MEM_BYTES);

    // Drop writes past the end; reads past the end return zero.
    always_ff @(posedge i_clk) begin
        if (i_req.wr && in_range) begin
            r_mem[i_req.addr[AW-1:0]] <= i_req.wdata;
        end
        if (i_req.rd) begin
            r_rdata <= r_mem[i_req.addr[AW-1:0]];
            r_hit   <= in_range;
        end
    end

    assign o_rdata = r_hit ? r_rdata : 8'd0;

endmodule

`default_nettype wire

// ===== verif/byte_byte_jump_machine_test.sv =====
`default_nettype none

module byte_byte_jump_machine_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FAW  = bbjm_pkg::FAW;
    localparam int PC_W = bbjm_pkg::PC_W;

    // Shrink the machine so frames and the clearing sweep stay short.
    localparam int MEM_SIZE    = 131072;
    localparam int FRAME_STEPS = 64;
    localparam int RUN_CYCLES  = 5 + 11 * FRAME_STEPS;

    localparam logic [FAW-1:0] MEM_END = FAW'(MEM_SIZE);
    localparam logic [1:0] ACT_NONE = 2'd3;

    localparam int TOTAL_ITEMS    = 90;
    localparam int HOLD_AFTER     = 30;
    localparam int HOLD_CYCLES    = 3000;
    localparam int DRAIN_CYCLES   = RUN_CYCLES + 16;
    localparam int WATCHDOG_LIMIT = 4 * (MEM_SIZE + RUN_CYCLES + HOLD_CYCLES + 64);
    localparam int REPORT_LIMIT   = 10;

    typedef struct packed {
        logic [1:0]  action;
        logic [19:0] address;
        logic [15:0] frame_offset;
        logic [7:0]  data;
    } t_action_item;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic [1:0]  i_action = 2'd0;
    logic [19:0] i_address = 20'd0;
    logic [15:0] i_frame_offset = 16'd0;
    logic [7:0]  i_data = 8'd0;
    logic        i_stall = 1'b0;
    logic        o_stall;
    logic        o_valid;
    logic [7:0]  o_read_data;

    wire in_xfer  = i_valid && !o_stall;
    wire out_xfer = o_valid && !i_stall;

    // Items waiting to be offered, and read_data bytes owed by the block.
    t_action_item pending_q [$];
    logic [7:0]   expected_bytes [$];

    // Shadow copy of the machine state.
    logic [7:0]    shadow_mem [MEM_SIZE];
    logic [PC_W-1:0] shadow_pc;

    int unsigned tx_gap;
    int unsigned rx_stall_left;
    int unsigned hold_left;
    logic        hold_done;
    int unsigned idle_cycles;

    int n_in;
    int n_checked;
    int n_writes;
    int n_runs;
    int n_reads;
    int error_count;

    byte_byte_jump_machine #(
        .MEM_BYTES       (MEM_SIZE),
        .STEPS_PER_FRAME (FRAME_STEPS)
    ) DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_action       (i_action),
        .i_address      (i_address),
        .i_frame_offset (i_frame_offset),
        .i_data         (i_data),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_read_data    (o_read_data)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Shadow machine
    // ------------------------------------------------------------------

    // Reads past the end of memory come back as zero.
    function automatic logic [7:0] shadow_read(input logic [FAW-1:0] a);
        if (a < MEM_END) begin
            return shadow_mem[int'(a)];
        end
        return 8'h00;
    endfunction

    // Writes past the end of memory are dropped.
    function automatic void shadow_write(input logic [FAW-1:0] a, input logic [7:0] v);
        if (a < MEM_END) begin
            shadow_mem[int'(a)] = v;
        end
    endfunction

    // Big-endian 24-bit operand; the address never wraps at 24 bits.
    function automatic logic [23:0] fetch_addr24(input logic [FAW-1:0] a);
        return {shadow_read(a), shadow_read(a + 25'd1), shadow_read(a + 25'd2)};
    endfunction

    function automatic void exec_instruction();
        logic [FAW-1:0] pc_x;
        logic [23:0]    src;
        logic [23:0]    dst;
        logic [23:0]    nxt;
        pc_x = {1'b0, shadow_pc};
        src = fetch_addr24(pc_x);
        dst = fetch_addr24(pc_x + 25'd3);
        nxt = fetch_addr24(pc_x + 25'd6);
        shadow_write({1'b0, dst}, shadow_read({1'b0, src}));
        shadow_pc = nxt;
    endfunction

    // Apply one action to the shadow state and return the byte the block owes.
    function automatic logic [7:0] predict_action(input t_action_item it);
        logic [7:0]     result;
        logic [FAW-1:0] base;
        result = 8'h00;
        base = {5'b0, it.address};
        case (it.action)
            bbjm_pkg::ACT_WRITE: begin
                n_writes++;
                shadow_write(base, it.data);
            end
            bbjm_pkg::ACT_RUN: begin
                n_runs++;
                // Reload PC from the vector before every frame, then step.
                shadow_pc = fetch_addr24(bbjm_pkg::PC_VEC_ADDR);
                for (int k = 0; k < FRAME_STEPS; k++) begin
                    exec_instruction();
                end
            end
            bbjm_pkg::ACT_READ: begin
                n_reads++;
                // Only a frame that ends before the last byte of memory is readable.
                if (base + bbjm_pkg::FRAME_BYTES < MEM_END) begin
                    result = shadow_read(base + {9'b0, it.frame_offset});
                end
            end
            default: begin
                result = 8'h00;
            end
        endcase
        return result;
    endfunction

    // Mostly short gaps, often none, now and then a long one.
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 45) begin
            return 0;
        end
        if (r < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    // Operand addresses: mostly inside memory, some near the vector and
    // low program area, some anywhere in 24 bits (usually off the end).
    function automatic logic [23:0] pick_data_addr();
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r < 6) begin
            return 24'($urandom_range(0, MEM_SIZE - 1));
        end
        if (r < 8) begin
            return 24'($urandom_range(0, 'h1FF));
        end
        return 24'($urandom);
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    task automatic push_item(input logic [1:0] act, input logic [19:0] addr,
                             input logic [15:0] off, input logic [7:0] dat);
        t_action_item it;
        it.action = act;
        it.address = addr;
        it.frame_offset = off;
        it.data = dat;
        pending_q.push_back(it);
    endtask

    // Store a 24-bit operand big-endian, one write per byte.
    task automatic push_word24(input logic [19:0] addr, input logic [23:0] value);
        push_item(bbjm_pkg::ACT_WRITE, addr, 16'($urandom), value[23:16]);
        push_item(bbjm_pkg::ACT_WRITE, addr + 20'd1, 16'($urandom), value[15:8]);
        push_item(bbjm_pkg::ACT_WRITE, addr + 20'd2, 16'($urandom), value[7:0]);
    endtask

    // Read one byte back through a legal frame window where possible.
    task automatic push_frame_read(input logic [23:0] a);
        logic [19:0] base;
        if (a < 24'(MEM_SIZE - 1)) begin
            base = (a >= 24'h010000) ? 20'(a - 24'h00FFFF) : 20'h0;
            push_item(bbjm_pkg::ACT_READ, base, 16'(a - {4'h0, base}), 8'($urandom));
        end else begin
            push_item(bbjm_pkg::ACT_READ, 20'($urandom), 16'($urandom), 8'h00);
        end
    endtask

    // ------------------------------------------------------------------
    // Driver: offer pending items, hold payload while stalled
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_action_item item;
        int unsigned  gap_next;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            tx_gap <= 0;
            n_in <= 0;
            for (int k = 0; k < MEM_SIZE; k++) begin
                shadow_mem[k] = 8'h00;
            end
            shadow_pc = '0;
        end else begin
            gap_next = tx_gap;
            if (in_xfer) begin
                expected_bytes.push_back(predict_action(
                    {i_action, i_address, i_frame_offset, i_data}));
                n_in <= n_in + 1;
                gap_next = pick_gap();
            end
            if (i_valid && !in_xfer) begin
                // Hold: stalled transfer keeps valid and payload steady.
            end else if (gap_next != 0) begin
                i_valid <= 1'b0;
                tx_gap <= gap_next - 1;
            end else if (pending_q.size() != 0) begin
                item = pending_q.pop_front();
                i_action <= item.action;
                i_address <= item.address;
                i_frame_offset <= item.frame_offset;
                i_data <= item.data;
                i_valid <= 1'b1;
                tx_gap <= 0;
            end else begin
                i_valid <= 1'b0;
                tx_gap <= 0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Long receiver hold-off, once, so the block backs up into its input
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_left <= 0;
            hold_done <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end else if (!hold_done && n_in >= HOLD_AFTER) begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Monitor: check each result transfer, drive random stalls
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        logic [7:0]  want;
        logic        rx_want;
        int unsigned g;
        if (!i_rst_n) begin
            i_stall <= 1'b0;
            rx_stall_left <= 0;
            n_checked <= 0;
            error_count = 0;
        end else begin
            if (out_xfer) begin
                n_checked <= n_checked + 1;
                if (expected_bytes.size() == 0) begin
                    error_count++;
                    if (error_count <= REPORT_LIMIT) begin
                        $display("%0t: result %02h arrived with nothing outstanding",
                                 $realtime, o_read_data);
                    end
                end else begin
                    want = expected_bytes.pop_front();
                    if (o_read_data !== want) begin
                        error_count++;
                        if (error_count <= REPORT_LIMIT) begin
                            $display("%0t: read_data of result %0d: expected %02h, got %02h",
                                     $realtime, n_checked, want, o_read_data);
                        end
                    end
                end
            end
            if (rx_stall_left != 0) begin
                rx_stall_left <= rx_stall_left - 1;
                rx_want = 1'b1;
            end else if ($urandom_range(0, 3) == 0) begin
                g = pick_gap();
                rx_stall_left <= g;
                rx_want = (g != 0);
            end else begin
                rx_want = 1'b0;
            end
            i_stall <= rx_want || (hold_left != 0);
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: too long without any transfer means the block is stuck
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n || in_xfer || out_xfer) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $realtime, idle_cycles);
            $display("Regression FAIL");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // Sequence: build stimulus, reset, drain, report
    // ------------------------------------------------------------------
    initial begin
        int unsigned kind;
        int unsigned n_ins;
        logic [23:0] entry;
        logic [23:0] here;
        logic [23:0] nxt;
        logic [23:0] dst_addr [3];

        // Directed: a freshly cleared memory reads zero.
        push_item(bbjm_pkg::ACT_READ, 20'h00000, 16'h0000, 8'h00);
        // Unused action with every field at its top value.
        push_item(ACT_NONE, 20'hFFFFF, 16'hFFFF, 8'hFF);
        // Writes at both ends of memory, and two past the end that drop.
        push_item(bbjm_pkg::ACT_WRITE, 20'h00000, 16'hFFFF, 8'hFF);
        push_item(bbjm_pkg::ACT_WRITE, 20'(MEM_SIZE - 1), 16'h0000, 8'hA5);
        push_item(bbjm_pkg::ACT_WRITE, 20'hFFFFF, 16'h0000, 8'h5A);
        push_item(bbjm_pkg::ACT_WRITE, 20'(MEM_SIZE), 16'h0000, 8'h3C);
        push_item(bbjm_pkg::ACT_WRITE, 20'(MEM_SIZE - 2), 16'h0000, 8'h81);
        // Highest byte a frame read can reach, then frames that reach the last byte or beyond.
        push_item(bbjm_pkg::ACT_READ, 20'(MEM_SIZE - 65537), 16'hFFFF, 8'h00);
        push_item(bbjm_pkg::ACT_READ, 20'(MEM_SIZE - 65536), 16'h0000, 8'h00);
        push_item(bbjm_pkg::ACT_READ, 20'hFFFFF, 16'hFFFF, 8'h00);
        // Program: vector points at 16; that instruction copies the last
        // byte to 0x100 and jumps so the next fetch straddles the end of
        // memory. From there the machine falls into the code at 0, whose
        // source lies past the end.
        push_word24(20'(bbjm_pkg::PC_VEC_ADDR), 24'h000010);
        push_word24(20'h00010, 24'(MEM_SIZE - 1));
        push_word24(20'h00013, 24'h000100);
        push_word24(20'h00016, 24'(MEM_SIZE - 4));
        push_item(bbjm_pkg::ACT_RUN, 20'h00000, 16'h0000, 8'h00);
        push_item(bbjm_pkg::ACT_READ, 20'h00000, 16'h0100, 8'h00);

        // Random: mostly self-contained programs with random operands,
        // run and read back, mixed with noise items and stray reads.
        while (pending_q.size() < TOTAL_ITEMS) begin
            kind = $urandom_range(0, 9);
            if (kind < 3) begin
                push_item(2'($urandom_range(0, 3)), 20'($urandom), 16'($urandom),
                          8'($urandom));
            end else if (kind < 5) begin
                push_item(bbjm_pkg::ACT_READ, 20'($urandom_range(0, 'hFFFF)),
                          16'($urandom), 8'($urandom));
            end else begin
                n_ins = $urandom_range(1, 3);
                entry = 24'($urandom_range(16, 'hFF00));
                push_word24(20'(bbjm_pkg::PC_VEC_ADDR), entry);
                for (int k = 0; k < n_ins; k++) begin
                    here = entry + 24'(9 * k);
                    dst_addr[k] = pick_data_addr();
                    if (k < n_ins - 1) begin
                        nxt = here + 24'd9;
                    end else if ($urandom_range(0, 3) == 0) begin
                        nxt = 24'($urandom);
                    end else begin
                        nxt = entry;
                    end
                    push_word24(20'(here), pick_data_addr());
                    push_word24(20'(here + 24'd3), dst_addr[k]);
                    push_word24(20'(here + 24'd6), nxt);
                end
                push_item(bbjm_pkg::ACT_RUN, 20'($urandom), 16'($urandom), 8'($urandom));
                for (int k = 0; k < n_ins; k++) begin
                    push_frame_read(dst_addr[k]);
                end
            end
        end

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Advance until every item is sent and every result is back.
        while (pending_q.size() != 0 || i_valid || expected_bytes.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        $display("Sent %0d actions: %0d writes, %0d frame runs, %0d frame reads.",
                 n_in, n_writes, n_runs, n_reads);
        $display("Checked %0d results, %0d errors, %0d results missing.",
                 n_checked, error_count, expected_bytes.size());
        if (error_count == 0 && expected_bytes.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ===== filelist.f =====
design/bbjm_pkg.sv
design/bbjm_mem.sv
design/byte_byte_jump_machine.sv
verif/byte_byte_jump_machine_test.sv
